// ===== rtl/core/mpsp_pkg.sv =====
package mpsp_pkg;

	// Default parameter values.
	localparam int POSITION_BITS_DEF = 32;
	localparam int DRIVE_LIMIT_DEF   = 150;

	// Fixed field widths.
	localparam int IN_BITS       = 32;
	localparam int GAIN_BITS     = 7;
	localparam int DRIVE_BITS    = 16;
	localparam int SPEED_I_BITS  = 9;
	localparam int HOLD_NUM_BITS = 20;
	localparam int CFG_IDX_BITS  = 3;

	// Speed integral saturation bound and hold integral step divisor.
	localparam int SPEED_I_MAX = 150;
	localparam logic [GAIN_BITS-1:0] HOLD_STEP_DIV = GAIN_BITS'(5);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_KP  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_DIV = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_KD  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPD_KP   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPD_KI   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPD_DIV  = 3'd5;

	// Configuration reset values.
	localparam logic [GAIN_BITS-1:0] RST_HOLD_KP  = 7'd8;
	localparam logic [GAIN_BITS-1:0] RST_HOLD_DIV = 7'd20;
	localparam logic [GAIN_BITS-1:0] RST_HOLD_KD  = 7'd40;
	localparam logic [GAIN_BITS-1:0] RST_SPD_KP   = 7'd1;
	localparam logic [GAIN_BITS-1:0] RST_SPD_KI   = 7'd2;
	localparam logic [GAIN_BITS-1:0] RST_SPD_DIV  = 7'd1;

	// Drive direction codes.
	localparam logic [1:0] DIR_BRAKE = 2'd0;
	localparam logic [1:0] DIR_CW    = 2'd1;
	localparam logic [1:0] DIR_CCW   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_DIV1,
		ST_DIV2
	} mpsp_state_t;

endpackage

// ===== rtl/core/mpsp_serial_div.sv =====
module mpsp_serial_div import mpsp_pkg::*; #(
	parameter int DW = HOLD_NUM_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] num,
	input  logic [GAIN_BITS-1:0] den,
	output logic                 busy,
	output logic signed [DW-1:0] quo
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]        sh_q;
	logic [GAIN_BITS-1:0] rem_q;
	logic [GAIN_BITS-1:0] den_q;
	logic                 neg_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [GAIN_BITS:0]   part;
	logic [GAIN_BITS:0]   trial;
	logic                 fits;

	// One quotient bit per cycle, restoring division on the magnitude.
	assign part  = {rem_q, sh_q[DW-1]};
	assign trial = part - {1'b0, den_q};
	assign fits  = part >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DW-1];
			sh_q  <= num[DW-1] ? DW'(-num) : DW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial[GAIN_BITS-1:0] : part[GAIN_BITS-1:0];
			sh_q  <= {sh_q[DW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? DW'(-sh_q) : DW'(sh_q);

endmodule

// ===== rtl/core/motor_position_speed_pid.sv =====
// Hold mode makes two divider passes per item and speed mode one; the divider length DW
// is the larger of POSITION_BITS and 20. Throughput: one item at a time; the next item
// is accepted once the result is registered, which waits until the previous result has
// been taken; the one-bit-per-cycle divider sets the rate (one or two passes per item).
// Reset: arst_n clears all loop history to zero and loads the register defaults.
module motor_position_speed_pid import mpsp_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int DRIVE_LIMIT   = DRIVE_LIMIT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic                    restart,
	input  logic signed [IN_BITS-1:0] position,
	input  logic signed [IN_BITS-1:0] target,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              pwm_compare,
	output logic [1:0]              drive_dir,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [GAIN_BITS-1:0]    cfg_data
);

	localparam int PW = POSITION_BITS;
	localparam int DW = (PW > HOLD_NUM_BITS) ? PW : HOLD_NUM_BITS;
	localparam int LIM_W = DRIVE_BITS + 1;

	mpsp_state_t state_q, state_d;

	// Configuration registers.
	logic [GAIN_BITS-1:0] hold_kp_q, hold_div_q, hold_kd_q;
	logic [GAIN_BITS-1:0] spd_kp_q, spd_ki_q, spd_div_q;

	// Loop history.
	logic signed [DRIVE_BITS-1:0]   hold_i_q, hold_last_q;
	logic signed [SPEED_I_BITS-1:0] spd_i_q;
	logic signed [PW-1:0]           spd_last_err_q, spd_last_pos_q;

	// Latched item.
	logic                 op_q, rst_q;
	logic [IN_BITS-1:0]   pos_q, tgt_q;

	// Working registers.
	logic signed [PW-1:0]         e_q;
	logic [DRIVE_BITS-1:0]        ma_q, mb_q, acc_q;
	logic [GAIN_BITS-1:0]         ga_q, gb_q;

	// Result register.
	logic       out_valid_q;
	logic [7:0] pwm_q;
	logic [1:0] dir_q;

	// Control.
	logic accept, do_prep1, do_prep2, div_start, mult_step, finish;

	// Divider connection.
	logic signed [DW-1:0]  div_num, div_quo;
	logic [GAIN_BITS-1:0]  div_den;
	logic                  div_busy;

	// Datapath intermediates.
	logic [63:0]                    pos_ext, tgt_ext;
	logic signed [PW-1:0]           pos_p, tgt_p;
	logic signed [PW-1:0]           spd_d;
	logic signed [PW:0]             spd_sum;
	logic signed [SPEED_I_BITS-1:0] spd_i_new;
	logic signed [DRIVE_BITS-1:0]   hold_d;
	logic signed [HOLD_NUM_BITS-1:0] hold_i20, hold_e20, hold_num;
	logic [DRIVE_BITS-1:0]          quo16;
	logic signed [DRIVE_BITS-1:0]   drive;
	logic signed [LIM_W-1:0]        drive17, lim17;
	logic [7:0]                     pwm_d;
	logic [1:0]                     dir_d;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_kp_q  <= RST_HOLD_KP;
			hold_div_q <= RST_HOLD_DIV;
			hold_kd_q  <= RST_HOLD_KD;
			spd_kp_q   <= RST_SPD_KP;
			spd_ki_q   <= RST_SPD_KI;
			spd_div_q  <= RST_SPD_DIV;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HOLD_KP:  hold_kp_q  <= cfg_data;
				CFG_HOLD_DIV: hold_div_q <= cfg_data;
				CFG_HOLD_KD:  hold_kd_q  <= cfg_data;
				CFG_SPD_KP:   spd_kp_q   <= cfg_data;
				CFG_SPD_KI:   spd_ki_q   <= cfg_data;
				CFG_SPD_DIV:  spd_div_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_PREP1;
			ST_PREP1: state_d = ST_PREP2;
			ST_PREP2: state_d = op_q ? ST_DIV2 : ST_DIV1;
			ST_DIV1:  if (!div_busy) state_d = ST_DIV2;
			ST_DIV2:  if (!div_busy && (!out_valid_q || out_ready)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		do_prep1  = 1'b0;
		do_prep2  = 1'b0;
		div_start = 1'b0;
		mult_step = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE:  ;
			ST_PREP1: do_prep1 = 1'b1;
			ST_PREP2: begin
				do_prep2  = 1'b1;
				div_start = 1'b1;
			end
			ST_DIV1: begin
				mult_step = 1'b1;
				div_start = !div_busy;
			end
			ST_DIV2: begin
				mult_step = 1'b1;
				finish    = !div_busy && (!out_valid_q || out_ready);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Inputs brought to the position width, wrapping or sign-extending.
	assign pos_ext = {{(64-IN_BITS){pos_q[IN_BITS-1]}}, pos_q};
	assign tgt_ext = {{(64-IN_BITS){tgt_q[IN_BITS-1]}}, tgt_q};
	assign pos_p   = pos_ext[PW-1:0];
	assign tgt_p   = tgt_ext[PW-1:0];

	// Hold step numerator 5*i + 4*e, and the change of hold error.
	assign hold_d   = DRIVE_BITS'(e_q[DRIVE_BITS-1:0] - hold_last_q);
	assign hold_i20 = HOLD_NUM_BITS'(hold_i_q);
	assign hold_e20 = HOLD_NUM_BITS'($signed(e_q[DRIVE_BITS-1:0]));
	assign hold_num = (hold_i20 <<< 2) + hold_i20 + (hold_e20 <<< 2);

	// Speed error change and the saturated integral.
	assign spd_d   = PW'(e_q - spd_last_err_q);
	assign spd_sum = (PW+1)'(e_q) + (PW+1)'(spd_i_q);
	always_comb begin
		if (spd_sum > (PW+1)'(SPEED_I_MAX)) begin
			spd_i_new = SPEED_I_BITS'(SPEED_I_MAX);
		end else if (spd_sum < -(PW+1)'(SPEED_I_MAX)) begin
			spd_i_new = -SPEED_I_BITS'(SPEED_I_MAX);
		end else begin
			spd_i_new = SPEED_I_BITS'(spd_sum);
		end
	end

	// Divider operand selection: the hold loop makes two passes, step then gain divide.
	always_comb begin
		if (state_q == ST_DIV1) begin
			div_num = DW'($signed(div_quo[DRIVE_BITS-1:0]));
			div_den = hold_div_q;
		end else if (op_q) begin
			div_num = DW'(spd_d);
			div_den = spd_div_q;
		end else begin
			div_num = DW'(hold_num);
			div_den = HOLD_STEP_DIV;
		end
	end

	mpsp_serial_div #(
		.DW(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			rst_q <= restart;
			pos_q <= position;
			tgt_q <= target;
		end
		if (do_prep1) begin
			// With a restart the last position equals the current one.
			e_q <= op_q ? PW'((rst_q ? pos_p : spd_last_pos_q) - pos_p + tgt_p)
				: PW'(tgt_p - pos_p);
		end
		if (do_prep2) begin
			acc_q <= '0;
			ma_q  <= e_q[DRIVE_BITS-1:0];
			if (op_q) begin
				mb_q <= DRIVE_BITS'(spd_i_new);
				ga_q <= spd_kp_q;
				gb_q <= spd_ki_q;
			end else begin
				mb_q <= hold_d;
				ga_q <= hold_kp_q;
				gb_q <= hold_kd_q;
			end
		end else if (mult_step) begin
			// Shift-and-add over the gain bits, both products at once.
			acc_q <= acc_q + (ga_q[0] ? ma_q : '0) + (gb_q[0] ? mb_q : '0);
			ma_q  <= {ma_q[DRIVE_BITS-2:0], 1'b0};
			mb_q  <= {mb_q[DRIVE_BITS-2:0], 1'b0};
			ga_q  <= ga_q >> 1;
			gb_q  <= gb_q >> 1;
		end
	end

	// Loop history, cleared at reset; a restart clears the selected loop's integral and last error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_i_q       <= '0;
			hold_last_q    <= '0;
			spd_i_q        <= '0;
			spd_last_err_q <= '0;
			spd_last_pos_q <= '0;
		end else begin
			if (do_prep1 && rst_q) begin
				if (op_q) begin
					spd_i_q        <= '0;
					spd_last_err_q <= '0;
				end else begin
					hold_i_q    <= '0;
					hold_last_q <= '0;
				end
			end
			if (do_prep2) begin
				if (op_q) begin
					spd_i_q        <= spd_i_new;
					spd_last_err_q <= e_q;
					spd_last_pos_q <= pos_p;
				end else begin
					hold_last_q <= e_q[DRIVE_BITS-1:0];
				end
			end
			if (state_q == ST_DIV1 && !div_busy) begin
				hold_i_q <= div_quo[DRIVE_BITS-1:0];
			end
		end
	end

	// Final sum and the drive to compare/direction mapping.
	always_comb begin
		if (op_q) begin
			quo16 = (spd_div_q == '0) ? '0 : div_quo[DRIVE_BITS-1:0];
		end else begin
			quo16 = (hold_div_q == '0) ? '0 : div_quo[DRIVE_BITS-1:0];
		end
	end

	assign drive   = DRIVE_BITS'(acc_q + quo16);
	assign drive17 = LIM_W'(drive);
	assign lim17   = LIM_W'(DRIVE_LIMIT);

	always_comb begin
		if (drive17 < -lim17) begin
			pwm_d = '0;
			dir_d = DIR_CCW;
		end else if (drive17 < 0) begin
			pwm_d = 8'(lim17 + drive17);
			dir_d = DIR_CCW;
		end else if (drive17 == 0) begin
			pwm_d = '0;
			dir_d = DIR_BRAKE;
		end else if (drive17 < lim17) begin
			pwm_d = 8'(lim17 - drive17);
			dir_d = DIR_CW;
		end else begin
			pwm_d = '0;
			dir_d = DIR_CW;
		end
	end

	// Result register: holds one item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			pwm_q <= pwm_d;
			dir_q <= dir_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_compare = pwm_q;
	assign drive_dir   = dir_q;

endmodule
